>>> hw/rtl/ppba_pkg.sv
// Shared types, constants and helper functions of the page bitmap allocator.
`default_nettype none

package ppba_pkg;

  localparam int DEF_BITMAP_WORDS = 1024;
  localparam int PAGE_SHIFT       = 12;
  localparam int WORD_SHIFT       = 5;
  localparam int HINT_W           = 11;
  localparam int CFG_W            = 11;
  localparam int PAGE_W           = 21;
  localparam int WIDX_W           = 16;
  localparam int PADDR_W          = 3;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_RANGE  = 2'd1;
  localparam logic [1:0] OP_SINGLE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic REG_WORDS_IN_USE = 1'b0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] begin_address;
    logic [31:0] end_address;
    logic        mark_reserved;
  } cmd_t;

  typedef struct packed {
    logic [31:0] page_address;
    logic        found;
    logic        page_reserved;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [WIDX_W-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [WIDX_W-1:0] raddr;
  } ram_req_t;

  // Page number of an address rounded up; the top page rounds to 2^20, not 0.
  function automatic logic [PAGE_W-1:0] page_up(input logic [31:0] addr);
    logic [32:0] sum;
    sum = {1'b0, addr} + 33'd4095;
    return sum[32:PAGE_SHIFT];
  endfunction

  // Index of the lowest clear bit; the word must not be all ones.
  function automatic logic [4:0] lowest_clear(input logic [31:0] word);
    logic [31:0] onehot;
    logic [4:0]  idx;
    onehot = ~word & (word + 32'd1);
    idx = '0;
    for (int k = 0; k < 5; k++) begin
      for (int j = 0; j < 32; j++) begin
        if (((j >> k) & 1) == 1) begin
          idx[k] = idx[k] | onehot[j];
        end
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ppba_ram.sv
// Bitmap word store: one write port and one read port with registered read data.
`default_nettype none

module ppba_ram #(
  parameter int BITMAP_WORDS = ppba_pkg::DEF_BITMAP_WORDS
) (
  input  wire logic               clk,
  input  wire ppba_pkg::ram_req_t req,
  output logic [31:0]             rdata
);
  import ppba_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  logic [31:0] mem [BITMAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppba_cfg.sv
// APB register slave holding the number of bitmap words in use.
`default_nettype none

module ppba_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ppba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [ppba_pkg::CFG_W-1:0]          words_in_use
);
  import ppba_pkg::*;

  logic sel_words;

  assign sel_words = (paddr[PADDR_W-1:2] == REG_WORDS_IN_USE);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= '0;
    end else if (psel && penable && pwrite && sel_words) begin
      words_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = sel_words ? {{(32 - CFG_W){1'b0}}, words_in_use} : 32'd0;

endmodule

`default_nettype wire

>>> hw/rtl/ppba_engine.sv
// Command sequencer that clears, then reads, modifies and writes the bitmap words.
`default_nettype none

module ppba_engine #(
  parameter int BITMAP_WORDS = ppba_pkg::DEF_BITMAP_WORDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire ppba_pkg::cmd_t              cmd,
  output logic                             busy,
  output logic                             done,
  output ppba_pkg::rsp_t                   rsp,
  input  wire logic [ppba_pkg::CFG_W-1:0]  words_in_use,
  output ppba_pkg::ram_req_t               req,
  input  wire logic [31:0]                 rdata
);
  import ppba_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam logic [WIDX_W:0] BW17 = (WIDX_W + 1)'(BITMAP_WORDS);
  localparam logic [AW-1:0]   LAST_IDX = AW'(BITMAP_WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_RANGE = 3'd3;
  localparam logic [2:0] S_QUERY = 3'd4;

  logic [2:0]        state, state_next;
  logic [AW-1:0]     clr_idx, clr_idx_next;
  logic [HINT_W-1:0] hint, hint_next;
  logic [WIDX_W-1:0] cur_w, cur_w_next;
  logic [WIDX_W-1:0] first_w, first_w_next;
  logic [WIDX_W-1:0] last_w, last_w_next;
  logic [4:0]        lo, lo_next;
  logic [4:0]        hi, hi_next;
  logic              reserve, reserve_next;
  logic              done_next;
  rsp_t              rsp_next;

  logic [CFG_W-1:0]  size_w;
  logic [PAGE_W-1:0] page_in;
  logic [PAGE_W-1:0] end_pg;
  logic [PAGE_W-1:0] last_pg;
  logic              range_empty;
  logic [WIDX_W-1:0] start_w;
  logic [HINT_W:0]   hint_inc;
  logic [WIDX_W:0]   w_inc;
  logic [4:0]        alloc_bit;
  logic [4:0]        lo_eff, hi_eff;
  logic [31:0]       mask;

  assign busy = (state != S_IDLE);

  // Effective table size is the smaller of the register and the store depth.
  assign size_w = ((WIDX_W + 1)'(words_in_use) < BW17) ? words_in_use : BW17[CFG_W-1:0];

  assign page_in = page_up(cmd.begin_address);
  assign end_pg  = {1'b0, cmd.end_address[31:PAGE_SHIFT]};

  always_comb begin
    if (cmd.operation == OP_RANGE) begin
      range_empty = (page_in >= end_pg);
      last_pg     = end_pg - PAGE_W'(1);
    end else begin
      range_empty = 1'b0;
      last_pg     = page_in;
    end
  end

  assign start_w   = page_in[PAGE_W-1:WORD_SHIFT];
  assign hint_inc  = {1'b0, hint} + (HINT_W + 1)'(1);
  assign w_inc     = {1'b0, cur_w} + (WIDX_W + 1)'(1);
  assign alloc_bit = lowest_clear(rdata);
  assign lo_eff    = (cur_w == first_w) ? lo : 5'd0;
  assign hi_eff    = (cur_w == last_w) ? hi : 5'd31;
  assign mask      = (ALL_ONES >> (5'd31 - hi_eff)) & (ALL_ONES << lo_eff);

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    hint_next    = hint;
    cur_w_next   = cur_w;
    first_w_next = first_w;
    last_w_next  = last_w;
    lo_next      = lo;
    hi_next      = hi;
    reserve_next = reserve;
    done_next    = 1'b0;
    rsp_next     = '0;
    req          = '0;

    case (state)
      S_CLEAR: begin
        req.we       = 1'b1;
        req.waddr    = WIDX_W'(clr_idx);
        req.wdata    = ALL_ONES;
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (cmd.operation)
            OP_ALLOC: begin
              if (hint < size_w) begin
                req.re     = 1'b1;
                req.raddr  = WIDX_W'(hint);
                state_next = S_ALLOC;
              end else begin
                done_next = 1'b1;
              end
            end

            OP_RANGE, OP_SINGLE: begin
              reserve_next = cmd.mark_reserved;
              if (range_empty) begin
                done_next = 1'b1;
              end else begin
                // Freeing pulls the hint down to the first freed word.
                if (!cmd.mark_reserved && (start_w < WIDX_W'(hint))) begin
                  hint_next = start_w[HINT_W-1:0];
                end
                first_w_next = start_w;
                cur_w_next   = start_w;
                last_w_next  = last_pg[PAGE_W-1:WORD_SHIFT];
                lo_next      = page_in[4:0];
                hi_next      = last_pg[4:0];
                if ({1'b0, start_w} < BW17) begin
                  req.re     = 1'b1;
                  req.raddr  = start_w;
                  state_next = S_RANGE;
                end else begin
                  done_next = 1'b1;
                end
              end
            end

            default: begin
              if (page_in >= PAGE_W'({size_w, 5'd0})) begin
                done_next = 1'b1;
              end else begin
                req.re     = 1'b1;
                req.raddr  = start_w;
                lo_next    = page_in[4:0];
                state_next = S_QUERY;
              end
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (rdata != ALL_ONES) begin
          req.we                = 1'b1;
          req.waddr             = WIDX_W'(hint);
          req.wdata             = rdata | (32'd1 << alloc_bit);
          done_next             = 1'b1;
          rsp_next.page_address = {4'd0, hint, alloc_bit, 12'd0};
          rsp_next.found        = 1'b1;
          state_next            = S_IDLE;
        end else begin
          // The next word is fetched while this one is judged full.
          hint_next = hint_inc[HINT_W-1:0];
          if (hint_inc < (HINT_W + 1)'(size_w)) begin
            req.re    = 1'b1;
            req.raddr = WIDX_W'(hint_inc);
          end else begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      S_RANGE: begin
        req.we    = 1'b1;
        req.waddr = cur_w;
        req.wdata = reserve ? (rdata | mask) : (rdata & ~mask);
        if ((cur_w == last_w) || (w_inc >= BW17)) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cur_w_next = w_inc[WIDX_W-1:0];
          req.re     = 1'b1;
          req.raddr  = w_inc[WIDX_W-1:0];
        end
      end

      S_QUERY: begin
        done_next              = 1'b1;
        rsp_next.page_reserved = rdata[lo];
        state_next             = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      hint    <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      hint    <= hint_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_w   <= cur_w_next;
    first_w <= first_w_next;
    last_w  <= last_w_next;
    lo      <= lo_next;
    hi      <= hi_next;
    reserve <= reserve_next;
    rsp     <= rsp_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/physical_page_bitmap_allocator.sv
// Top level of the physical page bitmap allocator.
//
// One bit per 4 KiB page, 1 meaning reserved, held in BITMAP_WORDS words of
// 32 bits in a single-port-read, single-port-write memory. A command beat is
// taken when start is high and busy is low; its result appears on rsp for one
// cycle with done high, and must be taken then since there is no back-pressure.
// An allocation scans bitmap words from the search hint, a set range or set single
// page touches each word of its range, and a query reads the word of its page.
// The read of the next word overlaps the write of the current one on the memory's
// two ports. A beat that needs no memory access leaves busy low, so the next beat
// may follow in the done cycle. After reset busy stays high while every word is
// written to all ones; the search hint and words_in_use reset to zero.
// words_in_use is written over APB at byte address 0; the user must write it only
// while the block is idle, as the block itself does not enforce it.
`default_nettype none

module physical_page_bitmap_allocator #(
  parameter int BITMAP_WORDS = ppba_pkg::DEF_BITMAP_WORDS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire ppba_pkg::cmd_t                cmd,
  output logic                               done,
  output ppba_pkg::rsp_t                     rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ppba_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ppba_pkg::*;

  logic [CFG_W-1:0] words_in_use;
  ram_req_t         req;
  logic [31:0]      rdata;

  ppba_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .words_in_use (words_in_use)
  );

  ppba_engine #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .done         (done),
    .rsp          (rsp),
    .words_in_use (words_in_use),
    .req          (req),
    .rdata        (rdata)
  );

  ppba_ram #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/ppba_checker.sv
// Port-level checks of the page bitmap allocator, bound to the top level.
`default_nettype none

module ppba_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            done,
  input wire ppba_pkg::rsp_t  rsp
);
  import ppba_pkg::*;

  // The clearing pass holds off commands right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  // A result is only delivered once the engine is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result delivered while busy");

  // An accepted beat either completes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command neither finished nor busy");

  // A failed allocation reports address zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.found) |-> (rsp.page_address == 32'd0))
    else $error("nonzero page address without found");

  // Allocation and query answers never come from the same command.
  a_one_answer: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.found && rsp.page_reserved))
    else $error("found and page_reserved both set");

endmodule

bind physical_page_bitmap_allocator ppba_checker u_ppba_checker (.*);

`default_nettype wire

>>> tb/sv/physical_page_bitmap_allocator_checker.sv
// Checker for the page bitmap allocator: predicts every response beat and compares it.
`default_nettype none

module physical_page_bitmap_allocator_checker #(
  parameter int BITMAP_WORDS = ppba_pkg::DEF_BITMAP_WORDS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire ppba_pkg::cmd_t                cmd,
  input  wire logic                          done,
  input  wire ppba_pkg::rsp_t                rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ppba_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  input  wire logic                          pready,
  output int                                 failures,
  output int                                 pending
);
  import ppba_pkg::*;

  logic [31:0] model_bitmap [BITMAP_WORDS];
  int unsigned model_hint;
  int unsigned model_words;
  rsp_t        awaited_rsp [$];
  int          mismatch_count = 0;

  assign failures = mismatch_count;

  // Page number of an address rounded up to the next page boundary, never wrapped.
  function automatic int unsigned page_rounded_up(input logic [31:0] addr);
    logic [63:0] wide;
    wide = 64'(addr) + 64'd4095;
    return int'(wide >> PAGE_SHIFT);
  endfunction

  task automatic lower_hint_to(input int unsigned page);
    if ((page >> WORD_SHIFT) < model_hint) begin
      model_hint = page >> WORD_SHIFT;
    end
  endtask

  task automatic mark_bits(input int unsigned w, input logic [31:0] mask, input logic reserve);
    if (w < BITMAP_WORDS) begin
      if (reserve) begin
        model_bitmap[w] = model_bitmap[w] | mask;
      end else begin
        model_bitmap[w] = model_bitmap[w] & ~mask;
      end
    end
  endtask

  task automatic predict_rsp(input cmd_t c, output rsp_t r);
    int unsigned limit_words;
    int unsigned pg;
    int unsigned pg_end;
    int unsigned w;
    int unsigned w_first;
    int unsigned w_last;
    int unsigned lo;
    int unsigned hi;
    int unsigned b;
    r = '0;
    limit_words = (model_words < BITMAP_WORDS) ? model_words : BITMAP_WORDS;
    case (c.operation)
      OP_ALLOC: begin
        while (model_hint < limit_words && !r.found) begin
          if (model_bitmap[model_hint] != ALL_ONES) begin
            b = 0;
            while (b < 31 && model_bitmap[model_hint][b]) begin
              b++;
            end
            model_bitmap[model_hint][b] = 1'b1;
            r.page_address = 32'(((model_hint << WORD_SHIFT) + b) << PAGE_SHIFT);
            r.found = 1'b1;
          end else begin
            model_hint++;
          end
        end
      end
      OP_RANGE: begin
        pg = page_rounded_up(c.begin_address);
        pg_end = int'(c.end_address >> PAGE_SHIFT);
        // An empty or inverted range changes nothing, not even the hint.
        if (pg < pg_end) begin
          if (!c.mark_reserved) begin
            lower_hint_to(pg);
          end
          w_first = pg >> WORD_SHIFT;
          w_last = (pg_end - 1) >> WORD_SHIFT;
          for (w = w_first; w <= w_last && w < BITMAP_WORDS; w++) begin
            lo = (w == w_first) ? (pg & 31) : 0;
            hi = (w == w_last) ? ((pg_end - 1) & 31) : 31;
            mark_bits(w, (ALL_ONES >> (31 - hi)) & (ALL_ONES << lo), c.mark_reserved);
          end
        end
      end
      OP_SINGLE: begin
        pg = page_rounded_up(c.begin_address);
        if (!c.mark_reserved) begin
          lower_hint_to(pg);
        end
        mark_bits(pg >> WORD_SHIFT, 32'd1 << (pg & 31), c.mark_reserved);
      end
      default: begin
        pg = page_rounded_up(c.begin_address);
        if (pg < limit_words * 32) begin
          r.page_reserved = model_bitmap[pg >> WORD_SHIFT][pg & 31];
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < BITMAP_WORDS; i++) begin
        model_bitmap[i] = ALL_ONES;
      end
      model_hint = 0;
      model_words = 0;
      awaited_rsp.delete();
    end else begin
      if (done) begin
        if (awaited_rsp.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected response beat at %0t: page_address %h found %b reserved %b",
                     $time, rsp.page_address, rsp.found, rsp.page_reserved);
          end
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.page_address !== want.page_address || rsp.found !== want.found ||
              rsp.page_reserved !== want.page_reserved) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("response mismatch at %0t: page_address exp %h got %h, %s",
                       $time, want.page_address, rsp.page_address,
                       $sformatf("found exp %b got %b, reserved exp %b got %b",
                                 want.found, rsp.found, want.page_reserved,
                                 rsp.page_reserved));
            end
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_WORDS_IN_USE) begin
        model_words = int'(pwdata[CFG_W-1:0]);
      end
      if (start && !busy) begin
        predict_rsp(cmd, want);
        awaited_rsp.push_back(want);
      end
    end
    pending <= awaited_rsp.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/physical_page_bitmap_allocator_tb.sv
// Testbench top for the page bitmap allocator: clock, reset, stimulus and verdict.
`default_nettype none

module physical_page_bitmap_allocator_tb;
  import ppba_pkg::*;

  localparam int BITMAP_WORDS    = DEF_BITMAP_WORDS;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 212;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  cmd_t               cmd     = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic               busy;
  logic               done;
  rsp_t               rsp;
  logic [31:0]        prdata;
  logic               pready;
  int                 failures;
  int                 pending;
  bit                 steady  = 1'b0;

  int unsigned phase_words [PHASES] = '{1024, 1, 37, 0, 1024, 5, 300, 2};

  always #5 clk = ~clk;

  physical_page_bitmap_allocator #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_top (
    .clk, .rst, .start, .busy, .cmd, .done, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  physical_page_bitmap_allocator_checker #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_chk (
    .clk, .rst, .start, .busy, .cmd, .done, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .failures, .pending
  );

  function automatic cmd_t make_cmd(input logic [1:0] op, input logic [31:0] b,
                                    input logic [31:0] e, input logic reserve);
    cmd_t c;
    c.operation = op;
    c.begin_address = b;
    c.end_address = e;
    c.mark_reserved = reserve;
    return c;
  endfunction

  // Mostly addresses inside the table or just past it; now and then anything at all.
  function automatic cmd_t random_cmd(input int unsigned words);
    cmd_t        c;
    int unsigned tw;
    int unsigned span;
    int unsigned pick;
    tw = (words > BITMAP_WORDS) ? BITMAP_WORDS : words;
    if (tw == 0) begin
      tw = 1;
    end
    span = tw * 32 + 64;
    pick = $urandom_range(0, 99);
    c.operation = (pick < 30) ? OP_ALLOC : (pick < 55) ? OP_RANGE :
                  (pick < 75) ? OP_SINGLE : OP_QUERY;
    c.begin_address = $urandom_range(0, span - 1) << PAGE_SHIFT;
    if ($urandom_range(0, 3) == 0) begin
      c.begin_address[11:0] = 12'($urandom);
    end
    c.end_address = c.begin_address + ($urandom_range(0, 96) << PAGE_SHIFT);
    if ($urandom_range(0, 3) == 0) begin
      c.end_address[11:0] = 12'($urandom);
    end
    if ($urandom_range(0, 15) == 0) begin
      c.begin_address = $urandom;
    end
    if ($urandom_range(0, 15) == 0) begin
      c.end_address = $urandom;
    end
    c.mark_reserved = ($urandom_range(0, 9) < 4);
    return c;
  endfunction

  task automatic issue(input cmd_t c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drops start and waits until every predicted response beat is in and the block is idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_words_in_use(input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_WORDS_IN_USE);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // The block clears its bitmap after reset and reports busy meanwhile.
    settle();

    // Table of zero words: nothing can be allocated and every query reads 0.
    issue(make_cmd(OP_ALLOC, 32'h0, 32'h0, 1'b0));
    issue(make_cmd(OP_QUERY, 32'h0, 32'hFFFF_FFFF, 1'b1));
    settle();
    write_words_in_use(11'd4);

    issue(make_cmd(OP_ALLOC, 32'h0, 32'h0, 1'b0));
    issue(make_cmd(OP_RANGE, 32'h0, 32'h0002_0000, 1'b0));
    issue(make_cmd(OP_ALLOC, 32'h0, 32'h0, 1'b0));
    issue(make_cmd(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    issue(make_cmd(OP_QUERY, 32'h0, 32'h0, 1'b0));
    issue(make_cmd(OP_QUERY, 32'h0000_1001, 32'h0, 1'b0));
    issue(make_cmd(OP_RANGE, 32'h0000_3001, 32'h0000_5000, 1'b0));
    issue(make_cmd(OP_RANGE, 32'h0000_9000, 32'h0000_1000, 1'b1));
    issue(make_cmd(OP_RANGE, 32'h0000_5000, 32'h0000_5000, 1'b0));
    // Addresses in the top page round up to a page number past 32 bits of address.
    issue(make_cmd(OP_SINGLE, 32'hFFFF_F001, 32'h0, 1'b0));
    issue(make_cmd(OP_SINGLE, 32'hFFFF_FFFF, 32'h0, 1'b1));
    issue(make_cmd(OP_QUERY, 32'hFFFF_FFFF, 32'h0, 1'b0));
    // A page in storage but past the table is written, yet queries read 0.
    issue(make_cmd(OP_SINGLE, 32'h0008_0000, 32'h0, 1'b0));
    issue(make_cmd(OP_QUERY, 32'h0008_0000, 32'h0, 1'b0));
    issue(make_cmd(OP_RANGE, 32'h0, 32'hFFFF_FFFF, 1'b1));
    issue(make_cmd(OP_ALLOC, 32'h0, 32'h0, 1'b0));
    issue(make_cmd(OP_SINGLE, 32'h0007_F000, 32'h0, 1'b0));
    issue(make_cmd(OP_ALLOC, 32'h0, 32'h0, 1'b0));
    issue(make_cmd(OP_RANGE, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0));
    issue(make_cmd(OP_RANGE, 32'h0000_1000, 32'h0003_F000, 1'b0));
    issue(make_cmd(OP_ALLOC, 32'h0, 32'h0, 1'b0));
    issue(make_cmd(OP_QUERY, 32'h0003_E000, 32'h0, 1'b1));
    issue(make_cmd(OP_SINGLE, 32'h0, 32'h0, 1'b1));
    issue(make_cmd(OP_QUERY, 32'h0, 32'h0, 1'b0));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_words_in_use(CFG_W'(phase_words[p]));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 40 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        issue(random_cmd(phase_words[p]));
      end
    end

    settle();
    repeat (BITMAP_WORDS + 16) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
